### src/rpcf_pkg.sv
// types and constants shared by the rgb pixel color filter
package rpcf_pkg;

  // filter mode codes, codes above fill pass the pixel through
  typedef enum logic [3:0] {
    MODE_PASS      = 4'd0,
    MODE_BGR       = 4'd1,
    MODE_GRB       = 4'd2,
    MODE_RBG       = 4'd3,
    MODE_BRG       = 4'd4,
    MODE_GBR       = 4'd5,
    MODE_SATURATE  = 4'd6,
    MODE_GRAY      = 4'd7,
    MODE_INVERT    = 4'd8,
    MODE_WARM      = 4'd9,
    MODE_COOL      = 4'd10,
    MODE_THRESHOLD = 4'd11,
    MODE_SEPIA     = 4'd12,
    MODE_FILL      = 4'd13
  } mode_t;

  // configuration register indexes
  localparam logic [7:0] REG_FILTER_MODE = 8'd0;
  localparam logic [7:0] REG_FILL_RED    = 8'd1;
  localparam logic [7:0] REG_FILL_GREEN  = 8'd2;
  localparam logic [7:0] REG_FILL_BLUE   = 8'd3;

  // luma weights
  localparam logic [7:0] LUMA_R = 8'd77;
  localparam logic [7:0] LUMA_G = 8'd150;
  localparam logic [7:0] LUMA_B = 8'd29;

  // sepia weights, one row per output channel
  localparam logic [6:0] SEP_RR = 7'd112;
  localparam logic [6:0] SEP_RG = 7'd88;
  localparam logic [6:0] SEP_RB = 7'd56;
  localparam logic [6:0] SEP_GR = 7'd100;
  localparam logic [6:0] SEP_GG = 7'd78;
  localparam logic [6:0] SEP_GB = 7'd48;
  localparam logic [6:0] SEP_BR = 7'd78;
  localparam logic [6:0] SEP_BG = 7'd61;
  localparam logic [6:0] SEP_BB = 7'd38;

  // saturation boost constants
  localparam logic [8:0] SAT_K_BASE = 9'd384;
  localparam logic [7:0] SAT_Y_MIN  = 8'd128;
  localparam logic [7:0] SAT_MAX    = 8'd240;

  // warm / cool offset and threshold level
  localparam logic [7:0] TINT_STEP  = 8'd20;
  localparam logic [7:0] THRESH_LVL = 8'd128;
  localparam logic [7:0] BYTE_ONES  = 8'hFF;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

endpackage

### src/rgb_pixel_color_filter_unit.sv
// rgb pixel color filter: three stage pipeline, one pixel per clock while the output side is ready
// throughput: one word per cycle unless the output stalls; multiplies by constants in stage one,
//   luma and saturation terms in stage two, saturation multiply in stage three
// reset: synchronous rst empties the pipeline and clears the filter registers to zero
// stalls: each stage holds its word until the next stage can take it
module rgb_pixel_color_filter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // in_red [7:0], in_green [15:8], in_blue [23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // out_red [7:0], out_green [15:8], out_blue [23:16]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // configuration registers
  logic [3:0] filter_mode;
  logic [7:0] fill_red;
  logic [7:0] fill_green;
  logic [7:0] fill_blue;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= rpcf_pkg::MODE_PASS;
      fill_red    <= 8'd0;
      fill_green  <= 8'd0;
      fill_blue   <= 8'd0;
    end else if (cfg_valid) begin
      if (cfg_index == rpcf_pkg::REG_FILTER_MODE) filter_mode <= cfg_data[3:0];
      if (cfg_index == rpcf_pkg::REG_FILL_RED)    fill_red    <= cfg_data;
      if (cfg_index == rpcf_pkg::REG_FILL_GREEN)  fill_green  <= cfg_data;
      if (cfg_index == rpcf_pkg::REG_FILL_BLUE)   fill_blue   <= cfg_data;
    end
  end

  // pipeline flow control
  logic v1, v2, v3;
  logic ready1, ready2, ready3;

  assign ready3   = !v3 || m_tready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign s_tready = ready1;
  assign m_tvalid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= s_tvalid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  // stage one: weighted sums for luma and sepia
  rpcf_pkg::pixel_t in_pix;
  logic [15:0] luma_sum_next, sep_r_next, sep_g_next, sep_b_next;

  assign in_pix = s_tdata;

  always_comb begin
    luma_sum_next = 16'(in_pix.red * rpcf_pkg::LUMA_R)
                  + 16'(in_pix.green * rpcf_pkg::LUMA_G)
                  + 16'(in_pix.blue * rpcf_pkg::LUMA_B);
    sep_r_next = 16'(in_pix.red * rpcf_pkg::SEP_RR)
               + 16'(in_pix.green * rpcf_pkg::SEP_RG)
               + 16'(in_pix.blue * rpcf_pkg::SEP_RB);
    sep_g_next = 16'(in_pix.red * rpcf_pkg::SEP_GR)
               + 16'(in_pix.green * rpcf_pkg::SEP_GG)
               + 16'(in_pix.blue * rpcf_pkg::SEP_GB);
    sep_b_next = 16'(in_pix.red * rpcf_pkg::SEP_BR)
               + 16'(in_pix.green * rpcf_pkg::SEP_BG)
               + 16'(in_pix.blue * rpcf_pkg::SEP_BB);
  end

  rpcf_pkg::pixel_t pix1;
  logic [3:0]  mode1;
  logic [15:0] luma_sum1, sep_r1, sep_g1, sep_b1;

  always_ff @(posedge clk) begin
    if (ready1) begin
      pix1      <= in_pix;
      mode1     <= filter_mode;
      luma_sum1 <= luma_sum_next;
      sep_r1    <= sep_r_next;
      sep_g1    <= sep_g_next;
      sep_b1    <= sep_b_next;
    end
  end

  // stage two: luma, per-mode result and saturation terms
  logic [7:0]        luma;
  logic [7:0]        luma_floor;
  logic [8:0]        sat_k_next;
  logic signed [11:0] n_r_next, n_g_next, n_b_next;
  rpcf_pkg::pixel_t  res_next;

  function automatic logic signed [11:0] sat_term(input logic [7:0] c, input logic [7:0] y);
    logic signed [8:0]  d;
    logic signed [11:0] d5;
    begin
      d  = $signed({1'b0, c}) - $signed({1'b0, y});
      d5 = 12'(d) * 12'sd5;
      sat_term = $signed({4'd0, y}) + (d5 >>> 1);
    end
  endfunction

  function automatic logic [7:0] clamp_byte(input logic [15:0] s);
    clamp_byte = (s[15:8] > 8'd0) ? 8'hFF : s[7:0];
  endfunction

  always_comb begin
    luma       = luma_sum1[15:8];
    luma_floor = (luma > rpcf_pkg::SAT_Y_MIN) ? luma : rpcf_pkg::SAT_Y_MIN;
    sat_k_next = rpcf_pkg::SAT_K_BASE - {1'b0, luma_floor};
    n_r_next   = sat_term(pix1.red, luma);
    n_g_next   = sat_term(pix1.green, luma);
    n_b_next   = sat_term(pix1.blue, luma);

    res_next = pix1;
    unique case (mode1)
      rpcf_pkg::MODE_BGR: begin
        res_next.red  = pix1.blue;
        res_next.blue = pix1.red;
      end
      rpcf_pkg::MODE_GRB: begin
        res_next.red   = pix1.green;
        res_next.green = pix1.red;
      end
      rpcf_pkg::MODE_RBG: begin
        res_next.green = pix1.blue;
        res_next.blue  = pix1.green;
      end
      rpcf_pkg::MODE_BRG: begin
        res_next.red   = pix1.blue;
        res_next.green = pix1.red;
        res_next.blue  = pix1.green;
      end
      rpcf_pkg::MODE_GBR: begin
        res_next.red   = pix1.green;
        res_next.green = pix1.blue;
        res_next.blue  = pix1.red;
      end
      rpcf_pkg::MODE_GRAY: begin
        res_next.red   = luma;
        res_next.green = luma;
        res_next.blue  = luma;
      end
      rpcf_pkg::MODE_INVERT: begin
        res_next.red   = pix1.red ^ rpcf_pkg::BYTE_ONES;
        res_next.green = pix1.green ^ rpcf_pkg::BYTE_ONES;
        res_next.blue  = pix1.blue ^ rpcf_pkg::BYTE_ONES;
      end
      rpcf_pkg::MODE_WARM: begin
        res_next.red  = clamp_byte(16'(pix1.red) + 16'(rpcf_pkg::TINT_STEP));
        res_next.blue = (pix1.blue < rpcf_pkg::TINT_STEP) ? 8'd0
                                                          : pix1.blue - rpcf_pkg::TINT_STEP;
      end
      rpcf_pkg::MODE_COOL: begin
        res_next.blue = clamp_byte(16'(pix1.blue) + 16'(rpcf_pkg::TINT_STEP));
        res_next.red  = (pix1.red < rpcf_pkg::TINT_STEP) ? 8'd0
                                                         : pix1.red - rpcf_pkg::TINT_STEP;
      end
      rpcf_pkg::MODE_THRESHOLD: begin
        res_next.red   = (luma >= rpcf_pkg::THRESH_LVL) ? 8'hFF : 8'd0;
        res_next.green = res_next.red;
        res_next.blue  = res_next.red;
      end
      rpcf_pkg::MODE_SEPIA: begin
        res_next.red   = clamp_byte({8'd0, sep_r1[15:8]});
        res_next.green = clamp_byte({8'd0, sep_g1[15:8]});
        res_next.blue  = clamp_byte({8'd0, sep_b1[15:8]});
      end
      rpcf_pkg::MODE_FILL: begin
        res_next.red   = fill_red;
        res_next.green = fill_green;
        res_next.blue  = fill_blue;
      end
      default: begin
        res_next = pix1;
      end
    endcase
  end

  rpcf_pkg::pixel_t   res2;
  logic               sat2;
  logic [8:0]         sat_k2;
  logic signed [11:0] n_r2, n_g2, n_b2;

  always_ff @(posedge clk) begin
    if (ready2) begin
      res2   <= res_next;
      sat2   <= (mode1 == rpcf_pkg::MODE_SATURATE);
      sat_k2 <= sat_k_next;
      n_r2   <= n_r_next;
      n_g2   <= n_g_next;
      n_b2   <= n_b_next;
    end
  end

  // stage three: saturation scale and clamp, output register
  function automatic logic [7:0] sat_scale(input logic signed [11:0] n,
                                           input logic [8:0] k);
    logic signed [21:0] p;
    logic signed [13:0] v;
    begin
      p = 22'(n) * $signed({13'd0, k});
      v = 14'(p >>> 8);
      if (v < 14'sd0) sat_scale = 8'd0;
      else if (v > $signed({6'd0, rpcf_pkg::SAT_MAX})) sat_scale = rpcf_pkg::SAT_MAX;
      else sat_scale = v[7:0];
    end
  endfunction

  rpcf_pkg::pixel_t res3_next;
  rpcf_pkg::pixel_t res3;
  logic             sat3;

  always_comb begin
    if (sat2) begin
      res3_next.red   = sat_scale(n_r2, sat_k2);
      res3_next.green = sat_scale(n_g2, sat_k2);
      res3_next.blue  = sat_scale(n_b2, sat_k2);
    end else begin
      res3_next = res2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3) begin
      res3 <= res3_next;
      sat3 <= sat2;
    end
  end

  assign m_tdata = res3;

`ifndef SYNTHESIS
  // a free output stage always lets the input side move
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output side ready");

  // reset returns the filter mode to pass-through
  a_reset_mode: assert property (@(posedge clk)
    rst |=> (filter_mode == rpcf_pkg::MODE_PASS))
    else $error("filter mode not cleared by reset");

  // saturation boost never exceeds its clamp ceiling
  a_sat_ceiling: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && sat3) |-> (m_tdata[7:0] <= rpcf_pkg::SAT_MAX &&
                            m_tdata[15:8] <= rpcf_pkg::SAT_MAX &&
                            m_tdata[23:16] <= rpcf_pkg::SAT_MAX))
    else $error("saturation result above ceiling");
`endif

endmodule

### tb/rgb_pixel_color_filter_unit_tb.sv
// testbench for the rgb pixel color filter unit: stream stimulus, per-pixel prediction, scoreboard
`timescale 1ns / 1ps

module rgb_pixel_color_filter_unit_tb;

  // spare mode codes, both pass the pixel through
  localparam logic [3:0] MODE_SPARE_LO = 4'd14;
  localparam logic [3:0] MODE_SPARE_HI = 4'd15;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 20;
  localparam int PHASE_WORDS = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  // pixels waiting to be sent and filtered pixels waiting to come back
  rpcf_pkg::pixel_t pending_px[$];
  rpcf_pkg::pixel_t expected_px[$];

  // shadow copy of the filter registers
  logic [3:0]       cur_mode = rpcf_pkg::MODE_PASS;
  rpcf_pkg::pixel_t cur_fill = '0;
  logic [7:0]       last_mode_cfg = {4'h0, rpcf_pkg::MODE_PASS};

  int   src_idle_pct = 0;
  int   sink_stall_pct = 0;
  logic long_hold = 1'b0;
  int   hold_cnt = 0;
  logic in_taken = 1'b0;
  int   stall_cycles = 0;
  int   err_count = 0;

  rgb_pixel_color_filter_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] clamp_byte(input int v);
    if (v > 255) return 8'hFF;
    return v[7:0];
  endfunction

  // one channel of the saturation boost, floor shifts, clamped to 0..240
  function automatic logic [7:0] boost_channel(input int c, input int gray, input int k);
    int n;
    int v;
    n = gray + (((c - gray) * 640) >>> 8);
    v = (n * k) >>> 8;
    if (v < 0) return 8'd0;
    if (v > 240) return 8'd240;
    return v[7:0];
  endfunction

  // filtered pixel for the given mode and fill color
  function automatic rpcf_pkg::pixel_t filter_pixel(input rpcf_pkg::pixel_t px,
                                                    input logic [3:0] mode,
                                                    input rpcf_pkg::pixel_t fill);
    int r;
    int g;
    int b;
    int y;
    int k;
    rpcf_pkg::pixel_t q;
    r = px.red;
    g = px.green;
    b = px.blue;
    y = (77 * r + 150 * g + 29 * b) >>> 8;
    q = px;
    case (mode)
      rpcf_pkg::MODE_BGR: begin
        q.red = px.blue;
        q.blue = px.red;
      end
      rpcf_pkg::MODE_GRB: begin
        q.red = px.green;
        q.green = px.red;
      end
      rpcf_pkg::MODE_RBG: begin
        q.green = px.blue;
        q.blue = px.green;
      end
      rpcf_pkg::MODE_BRG: begin
        q.red = px.blue;
        q.green = px.red;
        q.blue = px.green;
      end
      rpcf_pkg::MODE_GBR: begin
        q.red = px.green;
        q.green = px.blue;
        q.blue = px.red;
      end
      rpcf_pkg::MODE_SATURATE: begin
        k = 384 - ((y > 128) ? y : 128);
        q.red = boost_channel(r, y, k);
        q.green = boost_channel(g, y, k);
        q.blue = boost_channel(b, y, k);
      end
      rpcf_pkg::MODE_GRAY: begin
        q.red = y[7:0];
        q.green = y[7:0];
        q.blue = y[7:0];
      end
      rpcf_pkg::MODE_INVERT: q = ~px;
      rpcf_pkg::MODE_WARM: begin
        q.red = clamp_byte(r + 20);
        q.blue = (b < 20) ? 8'd0 : clamp_byte(b - 20);
      end
      rpcf_pkg::MODE_COOL: begin
        q.blue = clamp_byte(b + 20);
        q.red = (r < 20) ? 8'd0 : clamp_byte(r - 20);
      end
      rpcf_pkg::MODE_THRESHOLD: q = {24{y >= 128}};
      rpcf_pkg::MODE_SEPIA: begin
        q.red = clamp_byte((112 * r + 88 * g + 56 * b) >>> 8);
        q.green = clamp_byte((100 * r + 78 * g + 48 * b) >>> 8);
        q.blue = clamp_byte((78 * r + 61 * g + 38 * b) >>> 8);
      end
      rpcf_pkg::MODE_FILL: q = fill;
      default: ;
    endcase
    return q;
  endfunction

  function automatic logic [7:0] rand_byte();
    int v;
    v = $urandom_range(255);
    return v[7:0];
  endfunction

  // channel value biased toward the extremes
  function automatic logic [7:0] rand_chan();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return rand_byte();
    endcase
  endfunction

  function automatic rpcf_pkg::pixel_t rand_pixel();
    rpcf_pkg::pixel_t q;
    q.red = rand_chan();
    q.green = rand_chan();
    q.blue = rand_chan();
    return q;
  endfunction

  function automatic rpcf_pkg::pixel_t rgb(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
    rpcf_pkg::pixel_t q;
    q.red = r;
    q.green = g;
    q.blue = b;
    return q;
  endfunction

  // wait until no pixel is queued, offered or in flight
  task automatic settle();
    do @(posedge clk);
    while (pending_px.size() != 0 || s_tvalid || expected_px.size() != 0);
  endtask

  // one register write, shadow updated on the handshake
  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      rpcf_pkg::REG_FILTER_MODE: cur_mode = val[3:0];
      rpcf_pkg::REG_FILL_RED:    cur_fill.red = val;
      rpcf_pkg::REG_FILL_GREEN:  cur_fill.green = val;
      rpcf_pkg::REG_FILL_BLUE:   cur_fill.blue = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // directed pixel, switching mode only when the block is empty
  task automatic directed_px(input logic [7:0] mode_cfg, input rpcf_pkg::pixel_t px);
    if (mode_cfg != last_mode_cfg) begin
      settle();
      write_reg(rpcf_pkg::REG_FILTER_MODE, mode_cfg);
      last_mode_cfg = mode_cfg;
    end
    pending_px.push_back(px);
  endtask

  // input driver, next word once the current one is taken
  always @(negedge clk) begin
    if (!s_tvalid || in_taken) begin
      if (!rst && pending_px.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_px.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // output ready, random stalls plus one long hold-off
  always @(negedge clk) begin
    if (long_hold && hold_cnt < HOLD_CYCLES) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    rpcf_pkg::pixel_t want;
    rpcf_pkg::pixel_t got;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready)
        expected_px.push_back(filter_pixel(s_tdata, cur_mode, cur_fill));
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_px.size() == 0) begin
          $error("output word with no pending pixel: %h", m_tdata);
          err_count = err_count + 1;
        end else begin
          want = expected_px.pop_front();
          if (got.red !== want.red) begin
            $error("out_red: expected %0d, got %0d", want.red, got.red);
            err_count = err_count + 1;
          end
          if (got.green !== want.green) begin
            $error("out_green: expected %0d, got %0d", want.green, got.green);
            err_count = err_count + 1;
          end
          if (got.blue !== want.blue) begin
            $error("out_blue: expected %0d, got %0d", want.blue, got.blue);
            err_count = err_count + 1;
          end
        end
      end
    end
  end

  // watchdog on cycles with no word moving anywhere
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("rgb_pixel_color_filter_unit_tb: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers at reset: pass-through
    directed_px({4'h0, rpcf_pkg::MODE_PASS}, rgb(8'h00, 8'h00, 8'h00));
    directed_px({4'h0, rpcf_pkg::MODE_PASS}, rgb(8'hFF, 8'hFF, 8'hFF));
    // channel permutations
    directed_px({4'h0, rpcf_pkg::MODE_BGR}, rgb(8'd10, 8'd20, 8'd30));
    directed_px({4'h0, rpcf_pkg::MODE_GRB}, rgb(8'd10, 8'd20, 8'd30));
    directed_px({4'h0, rpcf_pkg::MODE_RBG}, rgb(8'd10, 8'd20, 8'd30));
    directed_px({4'h0, rpcf_pkg::MODE_BRG}, rgb(8'd10, 8'd20, 8'd30));
    directed_px({4'h0, rpcf_pkg::MODE_GBR}, rgb(8'd10, 8'd20, 8'd30));
    // saturation boost, written with the upper data bits set
    directed_px({4'hF, rpcf_pkg::MODE_SATURATE}, rgb(8'h00, 8'h00, 8'h00));
    directed_px({4'hF, rpcf_pkg::MODE_SATURATE}, rgb(8'hFF, 8'hFF, 8'hFF));
    directed_px({4'hF, rpcf_pkg::MODE_SATURATE}, rgb(8'hFF, 8'h00, 8'h00));
    directed_px({4'hF, rpcf_pkg::MODE_SATURATE}, rgb(8'h00, 8'hFF, 8'h00));
    directed_px({4'hF, rpcf_pkg::MODE_SATURATE}, rgb(8'h00, 8'h00, 8'hFF));
    directed_px({4'hF, rpcf_pkg::MODE_SATURATE}, rgb(8'd128, 8'd128, 8'd128));
    directed_px({4'h0, rpcf_pkg::MODE_GRAY}, rgb(8'd200, 8'd100, 8'd50));
    directed_px({4'h0, rpcf_pkg::MODE_INVERT}, rgb(8'h00, 8'hFF, 8'hA5));
    // warm and cool at the saturation edges
    directed_px({4'h0, rpcf_pkg::MODE_WARM}, rgb(8'd236, 8'd7, 8'd19));
    directed_px({4'h0, rpcf_pkg::MODE_WARM}, rgb(8'd235, 8'd7, 8'd20));
    directed_px({4'h0, rpcf_pkg::MODE_COOL}, rgb(8'd19, 8'd7, 8'd236));
    directed_px({4'h0, rpcf_pkg::MODE_COOL}, rgb(8'd20, 8'd7, 8'd235));
    // luma just below and at the threshold
    directed_px({4'h0, rpcf_pkg::MODE_THRESHOLD}, rgb(8'd127, 8'd127, 8'd127));
    directed_px({4'h0, rpcf_pkg::MODE_THRESHOLD}, rgb(8'd128, 8'd128, 8'd128));
    directed_px({4'h0, rpcf_pkg::MODE_SEPIA}, rgb(8'hFF, 8'hFF, 8'hFF));
    settle();
    write_reg(rpcf_pkg::REG_FILL_RED, 8'h5A);
    write_reg(rpcf_pkg::REG_FILL_GREEN, 8'hC3);
    write_reg(rpcf_pkg::REG_FILL_BLUE, 8'h81);
    directed_px({4'h0, rpcf_pkg::MODE_FILL}, rgb(8'd1, 8'd2, 8'd3));
    directed_px({4'h0, MODE_SPARE_LO}, rgb(8'd4, 8'd5, 8'd6));
    directed_px({4'h0, MODE_SPARE_HI}, rgb(8'd7, 8'd8, 8'd9));

    // random phases, each with its own registers and idle profile
    for (int p = 0; p < PHASES; p++) begin
      int t;
      logic [3:0] m;
      rpcf_pkg::pixel_t f;
      settle();
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 79; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 79; end
        default: begin src_idle_pct = 10; sink_stall_pct = 10; end
      endcase
      // every mode once, then fill at both extremes, saturate and a random one
      if (p < 16) begin
        t = p * 5;
        m = t[3:0];
      end else if (p < 18) begin
        m = rpcf_pkg::MODE_FILL;
      end else if (p == 18) begin
        m = rpcf_pkg::MODE_SATURATE;
      end else begin
        t = $urandom_range(15);
        m = t[3:0];
      end
      if (p == 16) f = '1;
      else if (p == 17) f = '0;
      else f = {rand_byte(), rand_byte(), rand_byte()};
      t = $urandom_range(15);
      write_reg(rpcf_pkg::REG_FILTER_MODE, {t[3:0], m});
      write_reg(rpcf_pkg::REG_FILL_RED, f.red);
      write_reg(rpcf_pkg::REG_FILL_GREEN, f.green);
      write_reg(rpcf_pkg::REG_FILL_BLUE, f.blue);
      // write to an unmapped index, must change nothing
      t = $urandom_range(255, 4);
      write_reg(t[7:0], rand_byte());
      if (p == 0) long_hold = 1'b1;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (p == 1 && i == PHASE_WORDS / 2) settle();
        pending_px.push_back(rand_pixel());
      end
      if (p == 0) begin
        wait (hold_cnt == HOLD_CYCLES);
        long_hold = 1'b0;
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (err_count == 0)
      $display("rgb_pixel_color_filter_unit_tb: done, clean");
    else
      $display("rgb_pixel_color_filter_unit_tb: done, errors");
    $finish;
  end

endmodule
